/* hdl/unsigned_decimal_text_formatter_macros.svh */
// ----------------------------------------------------------------------------
// unsigned decimal text formatter assertion macros
// shared property forms for the formatter checks
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DECIMAL_TEXT_FORMATTER_MACROS_SVH
`define UNSIGNED_DECIMAL_TEXT_FORMATTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UDTF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define UDTF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/udtf_pkg.sv */
// ----------------------------------------------------------------------------
// udtf_pkg
// constants and state type of the unsigned decimal text formatter
// ----------------------------------------------------------------------------
`default_nettype none

package udtf_pkg;

	// item field widths
	localparam int VALUE_W = 24;
	localparam int FW_W    = 4;
	localparam int CHAR_W  = 8;

	// decimal digits kept and largest field honored
	localparam int DIGITS    = 7;
	localparam int MAX_WIDTH = 15;

	// saturation limit, 10^DIGITS - 1
	localparam longint unsigned LIMIT = 64'(10 ** DIGITS) - 64'd1;

	// derived widths
	localparam int BCD_W = 4 * DIGITS;
	localparam int CNT_W = $clog2(VALUE_W);
	localparam int REM_W = $clog2(DIGITS + 1);
	localparam int POS_W = $clog2(MAX_WIDTH + 1);

	// characters
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} udtf_state_t;

endpackage

`default_nettype wire

/* hdl/unsigned_decimal_text_formatter.sv */
// ----------------------------------------------------------------------------
// unsigned decimal text formatter
// Prints an unsigned 24-bit value as decimal ASCII text, most significant
// digit first, one character per output item. Values above 9999999
// saturate to 9999999, leading zeros are dropped and zero prints as "0".
// With pad_enable set the text is left-justified in a field of field_width
// characters: short text is filled with spaces on the right, long text is
// cut to the field. Every run ends with a NUL character flagged by last.
// A new value is taken only when the previous run has been handed to the
// output register. Each item passes an accept step, bit-serial
// double-dabble conversion (one value bit per cycle), a leading zero skip
// (one dropped zero digit per step, plus a step that finds the first kept
// digit), then emission of its characters, up to 16 including the NUL,
// each of which waits while the output register is full and out_ready is
// low. The output register lets the final NUL wait for the consumer while
// the next value is already being converted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unsigned_decimal_text_formatter_macros.svh"

module unsigned_decimal_text_formatter
	import udtf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               pad_enable,
	input  wire logic [FW_W-1:0]    field_width,
	// output items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [CHAR_W-1:0]       character,
	output logic                    last
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

	udtf_state_t state_q, state_d;

	// conversion datapath
	logic [VALUE_W-1:0] bin_q;      // binary value, shifted out msb first
	logic [BCD_W-1:0]   bcd_q;      // packed bcd digits, most significant on top
	logic [CNT_W-1:0]   cnt_q;      // conversion step counter
	logic [REM_W-1:0]   rem_q;      // digits still to print
	logic [POS_W-1:0]   pos_q;      // characters printed in the field
	logic               pad_q;
	logic [POS_W-1:0]   width_q;    // clamped field width

	// output register
	logic               out_valid_q;
	logic [CHAR_W-1:0]  character_q;
	logic               last_q;

	// control
	logic               accept;
	logic               emit_ok;
	logic               end_run;
	logic               skip_more;
	logic               conv_step;
	logic               skip_step;
	logic               emit_step;
	logic [3:0]         top_digit;
	logic [CHAR_W-1:0]  char_d;
	logic [VALUE_W-1:0] value_sat;
	logic [BCD_W-1:0]   bcd_adj;

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign emit_ok   = !out_valid_q || out_ready;
	assign skip_more = (top_digit == 4'd0) && (rem_q > REM_W'(1));
	// bare text ends when the digits run out, padded text when the field is full
	assign end_run   = pad_q ? (pos_q == width_q) : (rem_q == '0);

	// saturate to the largest printable value
	assign value_sat = (64'(value) > LIMIT) ? VALUE_W'(LIMIT) : value;

	// double-dabble: add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!skip_more) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_ok && end_run) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		conv_step = 1'b0;
		skip_step = 1'b0;
		emit_step = 1'b0;
		char_d    = CHAR_NUL;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CONV: begin
				conv_step = 1'b1;
			end
			ST_SKIP: begin
				skip_step = skip_more;
			end
			ST_EMIT: begin
				emit_step = emit_ok;
				if (end_run) begin
					char_d = CHAR_NUL;
				end else if (rem_q != '0) begin
					char_d = CHAR_ZERO + {4'd0, top_digit};
				end else begin
					char_d = CHAR_SPACE;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				rem_q <= REM_W'(DIGITS);
				pos_q <= '0;
			end else if (conv_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (skip_step) begin
				rem_q <= rem_q - REM_W'(1);
			end else if (emit_step && !end_run) begin
				pos_q <= pos_q + POS_W'(1);
				if (rem_q != '0) begin
					rem_q <= rem_q - REM_W'(1);
				end
			end
			if (emit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q   <= value_sat;
			bcd_q   <= '0;
			pad_q   <= pad_enable;
			width_q <= (32'(field_width) > MAX_WIDTH) ? POS_W'(MAX_WIDTH)
				: POS_W'(field_width);
		end else if (conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end else if (skip_step || (emit_step && !end_run && rem_q != '0)) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (emit_step) begin
			character_q <= char_d;
			last_q      <= end_run;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	// checks
	`UDTF_ASSERT_NXT(a_conv_len, state_q == ST_CONV && cnt_q == CNT_LAST,
		state_q == ST_SKIP, "conversion did not end after the last value bit")
	`UDTF_ASSERT_IMP(a_last_nul, out_valid_q && last_q, character_q == CHAR_NUL,
		"end of run without a nul character")
	`UDTF_ASSERT_IMP(a_body_char, out_valid_q && !last_q,
		character_q == CHAR_SPACE || (character_q >= CHAR_ZERO
		&& character_q <= CHAR_ZERO + 8'd9), "text item is neither digit nor space")
	`UDTF_ASSERT_IMP(a_skip_keep, state_q == ST_SKIP, rem_q != '0,
		"leading zero skip removed every digit")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unsigned decimal text formatter. A table of
// directed values runs first, then about 250 random values. Each accepted
// value gets its expected character string, typed in the table or built by a
// local text predictor. Every output character is compared against the oldest pending
// character. Both sides idle at random, the output side holds off once for a
// long stretch, and the input side pauses until the output has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import udtf_pkg::*;

	// one expected output item: character plus end-of-run flag
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} text_char_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value       = '0;
	logic               pad_enable  = 1'b0;
	logic [FW_W-1:0]    field_width = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [CHAR_W-1:0]  character;
	logic               last;

	// characters still owed by the block, oldest first
	text_char_t pending_text[$];
	int         errors      = 0;
	// both sides skip idle cycles while set
	bit         no_idle     = 1'b0;
	// asks the output side for one long hold-off
	bit         hold_output = 1'b0;

	// directed table, one row per index
	logic [VALUE_W-1:0] row_value[$];
	logic               row_pad[$];
	logic [FW_W-1:0]    row_width[$];
	bit                 row_typed[$];
	string              row_text[$];

	unsigned_decimal_text_formatter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.pad_enable  (pad_enable),
		.field_width (field_width),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous time bound that fails a hung run
	initial begin
		#2000000;
		$display("** unsigned_decimal_text_formatter: FAILED **");
		$finish;
	end

	// expected text of one value: saturate, drop leading zeros, pad or cut
	function automatic void predict_text(input logic [VALUE_W-1:0] v, input logic pad,
			input logic [FW_W-1:0] fw);
		logic [CHAR_W-1:0] digits[$];
		longint unsigned   n;
		longint unsigned   scale;
		longint unsigned   dig;
		int                d;
		int                w;
		n = (v > LIMIT) ? LIMIT : longint'(v);
		scale = 1;
		for (d = 1; d < DIGITS; d++)
			scale = scale * 10;
		for (d = 0; d < DIGITS; d++) begin
			dig = n / scale;
			n = n - dig * scale;
			scale = scale / 10;
			if (digits.size() > 0 || dig != 0)
				digits.push_back(CHAR_ZERO + CHAR_W'(dig));
		end
		// zero still prints one digit
		if (digits.size() == 0)
			digits.push_back(CHAR_ZERO);
		if (pad) begin
			w = (fw > MAX_WIDTH) ? MAX_WIDTH : int'(fw);
			for (d = 0; d < w; d++)
				pending_text.push_back({(d < digits.size()) ? digits[d] : CHAR_SPACE, 1'b0});
		end else begin
			foreach (digits[d])
				pending_text.push_back({digits[d], 1'b0});
		end
		pending_text.push_back({CHAR_NUL, 1'b1});
	endfunction

	task automatic add_row(input logic [VALUE_W-1:0] v, input logic pad,
			input logic [FW_W-1:0] fw, input bit typed, input string txt);
		row_value.push_back(v);
		row_pad.push_back(pad);
		row_width.push_back(fw);
		row_typed.push_back(typed);
		row_text.push_back(txt);
	endtask

	// offer one value after a random gap; queue its text once accepted
	task automatic offer_value(input logic [VALUE_W-1:0] v, input logic pad,
			input logic [FW_W-1:0] fw, input bit typed, input string txt);
		int gap;
		int i;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		value       <= v;
		pad_enable  <= pad;
		field_width <= fw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// typed rows carry their text directly, the rest go through the predictor
		if (typed) begin
			for (i = 0; i < txt.len(); i++)
				pending_text.push_back({CHAR_W'(txt[i]), 1'b0});
			pending_text.push_back({CHAR_NUL, 1'b1});
		end else begin
			predict_text(v, pad, fw);
		end
	endtask

	// input side
	initial begin
		int                 n;
		int                 r;
		logic [VALUE_W-1:0] v;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// readable rows: typed text; others: predictor
		add_row(24'd0,        1'b0, 4'd0,  1'b1, "0");
		add_row(24'd0,        1'b1, 4'd0,  1'b1, "");
		add_row(24'd0,        1'b1, 4'd3,  1'b1, "0  ");
		add_row(24'd0,        1'b1, 4'd15, 1'b1, "0              ");
		add_row(24'hFFFFFF,   1'b0, 4'd0,  1'b1, "9999999");
		add_row(24'd10000000, 1'b0, 4'd9,  1'b1, "9999999");
		add_row(24'd9999999,  1'b0, 4'd2,  1'b1, "9999999");
		add_row(24'd9999999,  1'b1, 4'd15, 1'b1, "9999999        ");
		add_row(24'd9999999,  1'b1, 4'd4,  1'b1, "9999");
		add_row(24'd1000000,  1'b0, 4'd0,  1'b1, "1000000");
		add_row(24'd1,        1'b1, 4'd1,  1'b1, "1");
		add_row(24'd5,        1'b0, 4'd15, 1'b1, "5");
		add_row(24'd12345,    1'b1, 4'd0,  1'b1, "");
		add_row(24'd1000000,  1'b1, 4'd7,  1'b0, "");
		add_row(24'd42,       1'b1, 4'd9,  1'b0, "");
		add_row(24'd900,      1'b0, 4'd5,  1'b0, "");
		add_row(24'h800000,   1'b1, 4'd12, 1'b0, "");
		add_row(24'd10,       1'b1, 4'd2,  1'b0, "");
		add_row(24'd99,       1'b1, 4'd1,  1'b0, "");
		add_row(24'd123456,   1'b1, 4'd6,  1'b0, "");
		add_row(24'd7654321,  1'b1, 4'd8,  1'b0, "");
		add_row(24'h555555,   1'b0, 4'd10, 1'b0, "");
		add_row(24'hAAAAAA,   1'b1, 4'd10, 1'b0, "");
		add_row(24'd100,      1'b1, 4'd3,  1'b0, "");
		foreach (row_value[i])
			offer_value(row_value[i], row_pad[i], row_width[i], row_typed[i], row_text[i]);

		// let the directed part drain before the random part
		in_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);

		for (n = 0; n < 250; n++) begin
			// stretch with no idling on either side
			if (n == 60)
				no_idle = 1'b1;
			if (n == 100)
				no_idle = 1'b0;
			// back-to-back items against a stalled output: block fills up
			if (n == 130) begin
				no_idle     = 1'b1;
				hold_output = 1'b1;
			end
			if (n == 150)
				no_idle = 1'b0;
			// input pauses until the output has caught up
			if (n == 200) begin
				in_valid <= 1'b0;
				while (pending_text.size() != 0)
					@(posedge clk);
			end
			// mix of short numbers, decade edges, saturation edge and full range
			r = $urandom_range(0, 5);
			case (r)
				0: v = VALUE_W'($urandom_range(0, 9));
				1: v = VALUE_W'($urandom_range(0, 9999));
				2: v = VALUE_W'(10 ** $urandom_range(0, 7) - $urandom_range(0, 1));
				3: v = VALUE_W'($urandom_range(9999990, 10000010));
				default: v = VALUE_W'($urandom());
			endcase
			offer_value(v, 1'($urandom()), FW_W'($urandom()), 1'b0, "");
		end
		in_valid <= 1'b0;

		// wait for the last text, then watch a while for stray items
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("** unsigned_decimal_text_formatter: PASSED **");
		else
			$display("** unsigned_decimal_text_formatter: FAILED **");
		$finish;
	end

	// output side: random stalls, one long hold-off, check every item
	initial begin
		int         stall;
		text_char_t want;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_output = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_text.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual char %h last %b",
					$time, character, last);
			end else begin
				want = pending_text.pop_front();
				if (character !== want.ch) begin
					errors++;
					$display("%0t: character mismatch, expected %h, actual %h",
						$time, want.ch, character);
				end
				if (last !== want.fin) begin
					errors++;
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, want.fin, last);
				end
			end
		end
	end

endmodule

`default_nettype wire
